>>> rtl/lobm_pkg.sv
// Shared codes and field widths for the order book matcher.
`default_nettype none
package lobm_pkg;
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;
	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;
	localparam int QTY_W    = 20;
	localparam int TRADER_W = 8;
	localparam int TICKER_W = 4;
	localparam int STAMP_W  = 32;
	localparam int SEQ_W    = 32;
	localparam int INPRICE_W = 24;
endpackage
`default_nettype wire

>>> rtl/limit_order_book_matcher_unit.sv
// Top level of the limit order book matcher.
// Sequence: each fill takes a scan of the opposite side, a decide step and a fill
// step; the done beat follows a final scan and decide, or comes right after a fill
// that empties the order. A rejected order goes straight to its done beat.
// Throughput: one order at a time; in_stall stays high and no new order is taken
// until the done beat of the current order has been accepted.
// Reset: every book slot empty, trade and arrival counters zero; no clearing pass.
`default_nettype none
module limit_order_book_matcher_unit #(
	parameter int NUM_TICKERS     = 16,
	parameter int ORDERS_PER_SIDE = 16,
	parameter int PRICE_BITS      = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                action,
	input  wire logic [lobm_pkg::TRADER_W-1:0]       trader_id,
	input  wire logic [lobm_pkg::TICKER_W-1:0]       ticker_id,
	input  wire logic [lobm_pkg::QTY_W-1:0]          order_qty,
	input  wire logic [lobm_pkg::INPRICE_W-1:0]      limit_price,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     kind,
	output logic [lobm_pkg::TICKER_W-1:0]            trade_ticker,
	output logic [lobm_pkg::TRADER_W-1:0]            seller_id,
	output logic [lobm_pkg::TRADER_W-1:0]            buyer_id,
	output logic [lobm_pkg::QTY_W-1:0]               fill_qty,
	output logic [lobm_pkg::INPRICE_W-1:0]           fill_price,
	output logic [lobm_pkg::SEQ_W-1:0]               trade_seq,
	output logic [lobm_pkg::QTY_W-1:0]               rest_qty,
	output logic                                     book_full,
	output logic                                     last
);
	import lobm_pkg::*;
	localparam int NB = NUM_TICKERS * 2;
	localparam int IW = (ORDERS_PER_SIDE > 1) ? $clog2(ORDERS_PER_SIDE) : 1;
	localparam int BW = (NB > 1) ? $clog2(NB) : 1;
	localparam int CW = $clog2(ORDERS_PER_SIDE + 2);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_FILL, ST_DONE, ST_OUT
	} state_t;

	state_t                 state_q;
	logic                   side_q;
	logic [TRADER_W-1:0]    trader_q;
	logic [TICKER_W-1:0]    tick_q;
	logic [QTY_W-1:0]       qty_q;
	logic [PRICE_BITS-1:0]  price_q;
	logic [BW-1:0]          opp_q, own_q;
	logic [CW-1:0]          cnt_q;
	logic [SEQ_W-1:0]       trade_cnt_q;
	logic [STAMP_W-1:0]     arrival_q;
	logic [IW-1:0]          bidx_q;
	logic [PRICE_BITS-1:0]  bprice_q;
	logic [QTY_W-1:0]       opp_qty;
	logic                   ret_after_q;

	logic                   b_has   [NB];
	logic [PRICE_BITS-1:0]  b_price [NB];
	logic [IW-1:0]          b_idx   [NB];
	logic [QTY_W-1:0]       b_qty   [NB];
	logic [TRADER_W-1:0]    b_trd   [NB];
	logic                   b_free  [NB];
	logic [IW-1:0]          b_fidx  [NB];
	logic                   scan_en, scan_start, do_fill, do_ins;
	logic [QTY_W-1:0]       fq;
	logic                   crosses;

	assign in_stall = (state_q != ST_IDLE);
	assign scan_en    = (state_q == ST_SCAN);
	assign scan_start = (state_q == ST_SCAN) && (cnt_q == '0);

	for (genvar b = 0; b < NB; b++) begin : g_book
		logic [IW-1:0] aidx;
		assign aidx = (BW'(b) == own_q) ? b_fidx[b] : bidx_q;
		lobm_side #(.PW(PRICE_BITS), .NS(ORDERS_PER_SIDE), .IW(IW)) u_side (
			.clk(clk), .arst_n(arst_n),
			.sell_side((b % 2) == 1), .scan_en(scan_en && BW'(b) == opp_q),
			.scan_start(scan_start), .arrival(arrival_q),
			.best_has(b_has[b]), .best_price(b_price[b]), .best_idx(b_idx[b]),
			.acc_idx(aidx),
			.wr_en(do_ins && BW'(b) == own_q),
			.wr_price(price_q), .wr_qty(qty_q), .wr_trader(trader_q),
			.qty_en(do_fill && BW'(b) == opp_q), .qty_new(opp_qty - fq),
			.acc_qty(b_qty[b]), .acc_trader(b_trd[b]),
			.free_found(b_free[b]), .free_idx(b_fidx[b])
		);
	end

	assign opp_qty = b_qty[opp_q];
	assign fq = (qty_q < opp_qty) ? qty_q : opp_qty;
	assign do_fill = (state_q == ST_FILL) && !(out_valid && out_stall);
	assign do_ins  = (state_q == ST_DONE) && !ret_after_q && (qty_q != '0) && b_free[own_q]
		&& !(out_valid && out_stall);
	// buy takes sells at or below its limit; sell takes buys at or above
	assign crosses = side_q ? !(b_price[opp_q] < price_q) : !(b_price[opp_q] > price_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid   <= 1'b0;
			trade_cnt_q <= '0;
			arrival_q   <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (32'(ticker_id) >= NUM_TICKERS) begin
							state_q <= ST_DONE;
						end else if (order_qty == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
						cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CW'(ORDERS_PER_SIDE - 1)) begin
						state_q <= ST_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					if (b_has[opp_q] && crosses) begin
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_FILL: begin
					if (!(out_valid && out_stall)) begin
						out_valid   <= 1'b1;
						trade_cnt_q <= trade_cnt_q + 1'b1;
						cnt_q       <= '0;
						state_q     <= (qty_q == fq) ? ST_DONE : ST_SCAN;
					end
				end
				ST_DONE: begin
					if (!(out_valid && out_stall)) begin
						out_valid <= 1'b1;
						if (do_ins) begin
							arrival_q <= arrival_q + 1'b1;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!(out_valid && out_stall)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					side_q   <= action;
					trader_q <= trader_id;
					tick_q   <= ticker_id;
					qty_q    <= order_qty;
					price_q  <= PRICE_BITS'(limit_price);
					ret_after_q <= (32'(ticker_id) >= NUM_TICKERS);
					opp_q    <= BW'({ticker_id, ~action});
					own_q    <= BW'({ticker_id, action});
				end
			end
			ST_DECIDE: begin
				bidx_q   <= b_idx[opp_q];
				bprice_q <= b_price[opp_q];
			end
			ST_FILL: begin
				if (do_fill) begin
					kind         <= KIND_TRADE;
					trade_ticker <= tick_q;
					seller_id    <= side_q ? trader_q : b_trd[opp_q];
					buyer_id     <= side_q ? b_trd[opp_q] : trader_q;
					fill_qty     <= fq;
					fill_price   <= INPRICE_W'(side_q ? price_q : bprice_q);
					trade_seq    <= trade_cnt_q;
					rest_qty     <= '0;
					book_full    <= 1'b0;
					last         <= 1'b0;
					qty_q        <= qty_q - fq;
				end
			end
			ST_DONE: begin
				if (!(out_valid && out_stall)) begin
					kind         <= KIND_DONE;
					trade_ticker <= tick_q;
					seller_id    <= '0;
					buyer_id     <= '0;
					fill_qty     <= '0;
					fill_price   <= '0;
					trade_seq    <= '0;
					rest_qty     <= qty_q;
					book_full    <= ret_after_q || ((qty_q != '0) && !b_free[own_q]);
					last         <= 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/lobm_cell.sv
// One book slot: stored order plus compare-and-forward stage of the best-order scan.
`default_nettype none
module lobm_cell #(
	parameter int PW = 24,
	parameter int IW = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// scan chain
	input  wire logic                       in_has,
	input  wire logic [PW-1:0]              in_price,
	input  wire logic [lobm_pkg::STAMP_W-1:0] in_age,
	input  wire logic [IW-1:0]              in_idx,
	input  wire logic                       sell_side,
	input  wire logic                       scan_en,
	input  wire logic [lobm_pkg::STAMP_W-1:0] arrival,
	input  wire logic [IW-1:0]              my_idx,
	output logic                            out_has,
	output logic [PW-1:0]                   out_price,
	output logic [lobm_pkg::STAMP_W-1:0]    out_age,
	output logic [IW-1:0]                   out_idx,
	// access
	input  wire logic                       wr_en,
	input  wire logic                       wr_valid,
	input  wire logic [PW-1:0]              wr_price,
	input  wire logic [lobm_pkg::QTY_W-1:0] wr_qty,
	input  wire logic [lobm_pkg::TRADER_W-1:0] wr_trader,
	input  wire logic [lobm_pkg::STAMP_W-1:0] wr_stamp,
	input  wire logic                       qty_en,
	input  wire logic [lobm_pkg::QTY_W-1:0] qty_new,
	output logic                            valid,
	output logic [lobm_pkg::QTY_W-1:0]      qty,
	output logic [lobm_pkg::TRADER_W-1:0]   trader
);
	import lobm_pkg::*;
	logic                valid_q;
	logic [PW-1:0]       price_q;
	logic [QTY_W-1:0]    qty_q;
	logic [TRADER_W-1:0] trader_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [STAMP_W-1:0]  age;
	logic                better;

	assign age = arrival - stamp_q;
	// sell book: lowest price wins; buy book: highest price wins
	always_comb begin
		if (!valid_q) begin
			better = 1'b0;
		end else if (!in_has) begin
			better = 1'b1;
		end else if (price_q == in_price) begin
			better = age > in_age;
		end else begin
			better = sell_side ? (price_q < in_price) : (price_q > in_price);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			out_has <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q <= wr_valid;
			end else if (qty_en && qty_new == '0) begin
				valid_q <= 1'b0;
			end
			if (scan_en) begin
				out_has <= in_has | better;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			price_q  <= wr_price;
			qty_q    <= wr_qty;
			trader_q <= wr_trader;
			stamp_q  <= wr_stamp;
		end else if (qty_en) begin
			qty_q <= qty_new;
		end
		if (scan_en) begin
			out_price <= better ? price_q : in_price;
			out_age   <= better ? age : in_age;
			out_idx   <= better ? my_idx : in_idx;
		end
	end

	assign valid  = valid_q;
	assign qty    = qty_q;
	assign trader = trader_q;
endmodule
`default_nettype wire

>>> rtl/lobm_side.sv
// One book side: a chain of slot cells.
`default_nettype none
module lobm_side #(
	parameter int PW = 24,
	parameter int NS = 16,
	parameter int IW = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       sell_side,
	input  wire logic                       scan_en,
	input  wire logic                       scan_start,
	input  wire logic [lobm_pkg::STAMP_W-1:0] arrival,
	output logic                            best_has,
	output logic [PW-1:0]                   best_price,
	output logic [IW-1:0]                   best_idx,
	input  wire logic [IW-1:0]              acc_idx,
	input  wire logic                       wr_en,
	input  wire logic [PW-1:0]              wr_price,
	input  wire logic [lobm_pkg::QTY_W-1:0] wr_qty,
	input  wire logic [lobm_pkg::TRADER_W-1:0] wr_trader,
	input  wire logic                       qty_en,
	input  wire logic [lobm_pkg::QTY_W-1:0] qty_new,
	output logic [lobm_pkg::QTY_W-1:0]      acc_qty,
	output logic [lobm_pkg::TRADER_W-1:0]   acc_trader,
	output logic                            free_found,
	output logic [IW-1:0]                   free_idx
);
	import lobm_pkg::*;
	logic                has_c   [NS+1];
	logic [PW-1:0]       price_c [NS+1];
	logic [STAMP_W-1:0]  age_c   [NS+1];
	logic [IW-1:0]       idx_c   [NS+1];
	logic [NS-1:0]       vld;
	logic [QTY_W-1:0]    qty_a   [NS];
	logic [TRADER_W-1:0] trd_a   [NS];

	// The chain is fed with an empty candidate; each cell registers its result,
	// so a full scan needs scan_en held while the candidate passes through all NS cells.
	assign has_c[0]   = 1'b0;
	assign price_c[0] = '0;
	assign age_c[0]   = '0;
	assign idx_c[0]   = '0;

	for (genvar i = 0; i < NS; i++) begin : g_cell
		logic                ihas;
		logic [PW-1:0]       iprice;
		logic [STAMP_W-1:0]  iage;
		logic [IW-1:0]       iidx;
		assign ihas   = scan_start ? 1'b0 : has_c[i];
		assign iprice = price_c[i];
		assign iage   = age_c[i];
		assign iidx   = idx_c[i];
		lobm_cell #(.PW(PW), .IW(IW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_has(ihas), .in_price(iprice), .in_age(iage), .in_idx(iidx),
			.sell_side(sell_side), .scan_en(scan_en), .arrival(arrival),
			.my_idx(IW'(i)),
			.out_has(has_c[i+1]), .out_price(price_c[i+1]),
			.out_age(age_c[i+1]), .out_idx(idx_c[i+1]),
			.wr_en(wr_en && acc_idx == IW'(i)), .wr_valid(1'b1),
			.wr_price(wr_price), .wr_qty(wr_qty), .wr_trader(wr_trader),
			.wr_stamp(arrival),
			.qty_en(qty_en && acc_idx == IW'(i)), .qty_new(qty_new),
			.valid(vld[i]), .qty(qty_a[i]), .trader(trd_a[i])
		);
	end

	assign best_has   = has_c[NS];
	assign best_price = price_c[NS];
	assign best_idx   = idx_c[NS];
	assign acc_qty    = qty_a[acc_idx];
	assign acc_trader = trd_a[acc_idx];

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (!vld[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end
endmodule
`default_nettype wire

>>> dv/limit_order_book_matcher_unit_test.sv
// Self-checking testbench for the limit order book matcher: directed table, then random orders.
`default_nettype none
module limit_order_book_matcher_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lobm_pkg::*;

	localparam int NUM_TICKERS     = 16;
	localparam int ORDERS_PER_SIDE = 16;
	localparam int PRICE_BITS      = 24;
	localparam int NUM_SLOTS       = NUM_TICKERS * 2 * ORDERS_PER_SIDE;
	localparam int RANDOM_ORDERS   = 360;
	localparam int IDLE_LIMIT      = 20000;

	typedef struct packed {
		logic                 side;
		logic [TRADER_W-1:0]  trader;
		logic [TICKER_W-1:0]  ticker;
		logic [QTY_W-1:0]     qty;
		logic [INPRICE_W-1:0] price;
	} order_t;

	typedef struct packed {
		logic                 kind;
		logic [TICKER_W-1:0]  ticker;
		logic [TRADER_W-1:0]  seller;
		logic [TRADER_W-1:0]  buyer;
		logic [QTY_W-1:0]     qty;
		logic [INPRICE_W-1:0] price;
		logic [SEQ_W-1:0]     seq;
		logic [QTY_W-1:0]     rest;
		logic                 full;
		logic                 last;
	} fill_t;

	// Directed row: order plus optional typed-in done beat (only when no trades are expected).
	typedef struct {
		order_t ord;
		bit     has_done;
		fill_t  done_beat;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [TRADER_W-1:0] trader_id = '0;
	logic [TICKER_W-1:0] ticker_id = '0;
	logic [QTY_W-1:0] order_qty = '0;
	logic [INPRICE_W-1:0] limit_price = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [TICKER_W-1:0] trade_ticker;
	logic [TRADER_W-1:0] seller_id, buyer_id;
	logic [QTY_W-1:0] fill_qty, rest_qty;
	logic [INPRICE_W-1:0] fill_price;
	logic [SEQ_W-1:0] trade_seq;
	logic book_full, last;

	always #2 clk = ~clk;

	limit_order_book_matcher_unit #(
		.NUM_TICKERS(NUM_TICKERS), .ORDERS_PER_SIDE(ORDERS_PER_SIDE), .PRICE_BITS(PRICE_BITS)
	) i_dut (.*);

	// Book model
	bit                   book_valid[NUM_SLOTS];
	logic [INPRICE_W-1:0] book_price[NUM_SLOTS];
	logic [QTY_W-1:0]     book_qty[NUM_SLOTS];
	logic [TRADER_W-1:0]  book_trader[NUM_SLOTS];
	logic [STAMP_W-1:0]   book_stamp[NUM_SLOTS];
	logic [SEQ_W-1:0]     next_seq = '0;
	logic [STAMP_W-1:0]   next_stamp = '0;

	fill_t expected_beats[$];
	int errors = 0;
	int beats_seen = 0, trades_seen = 0, full_seen = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;

	function automatic void add_beat(fill_t b);
		expected_beats.insert(expected_beats.size(), b);
	endfunction

	function automatic fill_t make_done(logic [TICKER_W-1:0] t, logic [QTY_W-1:0] r,
			logic f);
		fill_t b;
		b = '0;
		b.kind = KIND_DONE;
		b.ticker = t;
		b.rest = r;
		b.full = f;
		b.last = 1'b1;
		return b;
	endfunction

	// Match one order against the book and queue its beats.
	task automatic match_order(order_t o);
		int opp, own, best, slot;
		logic [INPRICE_W-1:0] bp, price;
		logic [STAMP_W-1:0] bage, age;
		logic [QTY_W-1:0] q, fq;
		bit better, full;
		fill_t b;
		q = o.qty;
		price = o.price;
		full = 1'b0;
		if (o.ticker >= NUM_TICKERS) begin
			add_beat(make_done(o.ticker, q, 1'b1));
			return;
		end
		opp = (o.ticker * 2 + (o.side ^ 1)) * ORDERS_PER_SIDE;
		own = (o.ticker * 2 + o.side) * ORDERS_PER_SIDE;
		while (q > 0) begin
			best = -1;
			bp = '0;
			bage = '0;
			for (int s = 0; s < ORDERS_PER_SIDE; s++) begin
				if (!book_valid[opp + s]) continue;
				age = next_stamp - book_stamp[opp + s];
				if (best < 0) better = 1'b1;
				else if (book_price[opp + s] == bp) better = age > bage;
				else if (o.side == SIDE_SELL) better = book_price[opp + s] > bp;
				else better = book_price[opp + s] < bp;
				if (better) begin
					best = s;
					bp = book_price[opp + s];
					bage = age;
				end
			end
			if (best < 0) break;
			if (o.side == SIDE_SELL ? (bp < price) : (bp > price)) break;
			fq = q < book_qty[opp + best] ? q : book_qty[opp + best];
			b = '0;
			b.kind = KIND_TRADE;
			b.ticker = o.ticker;
			b.seller = o.side == SIDE_SELL ? o.trader : book_trader[opp + best];
			b.buyer = o.side == SIDE_SELL ? book_trader[opp + best] : o.trader;
			b.qty = fq;
			b.price = o.side == SIDE_SELL ? price : bp;
			b.seq = next_seq;
			add_beat(b);
			next_seq++;
			q -= fq;
			book_qty[opp + best] -= fq;
			if (book_qty[opp + best] == 0) book_valid[opp + best] = 1'b0;
		end
		if (q > 0) begin
			slot = -1;
			for (int s = 0; s < ORDERS_PER_SIDE; s++)
				if (slot < 0 && !book_valid[own + s]) slot = s;
			if (slot < 0) full = 1'b1;
			else begin
				book_valid[own + slot] = 1'b1;
				book_price[own + slot] = price;
				book_qty[own + slot] = q;
				book_trader[own + slot] = o.trader;
				book_stamp[own + slot] = next_stamp;
				next_stamp++;
			end
		end
		add_beat(make_done(o.ticker, q, full));
	endtask

	// Present one order and hold it until accepted, with bursty gaps.
	int burst_left = 0;
	task automatic send_order(order_t o);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 30)) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		{action, trader_id, ticker_id, order_qty, limit_price} <= o;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		match_order(o);
		burst_left--;
	endtask

	function automatic order_t random_order();
		order_t o;
		int sel;
		o.side = 1'($urandom_range(0, 1));
		o.trader = TRADER_W'($urandom);
		o.ticker = TICKER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
			: $urandom_range(0, 2));
		sel = $urandom_range(0, 19);
		if (sel == 0) o.qty = '0;
		else if (sel == 1) o.qty = QTY_W'($urandom);
		else if (sel == 2) o.qty = QTY_W'({QTY_W{1'b1}} - $urandom_range(0, 3));
		else o.qty = QTY_W'($urandom_range(1, 60));
		sel = $urandom_range(0, 19);
		if (sel == 0) o.price = INPRICE_W'($urandom);
		else if (sel == 1) o.price = INPRICE_W'({INPRICE_W{1'b1}} - $urandom_range(0, 2));
		else o.price = INPRICE_W'(1000 + $urandom_range(0, 12));
		return o;
	endfunction

	row_t dir_rows[$];

	function automatic void add_row(row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic row_t mk(logic sd, logic [7:0] tr, logic [3:0] tk, logic [19:0] q,
			logic [23:0] p, bit hd = 0, logic [19:0] r = 0, logic f = 0);
		row_t x;
		x.ord = '{sd, tr, tk, q, p};
		x.has_done = hd;
		x.done_beat = make_done(tk, r, f);
		return x;
	endfunction

	initial begin
		// Empty book: orders rest with nothing traded.
		add_row(mk(SIDE_BUY,  8'h00, 4'd0, 20'd10, 24'd0, 1, 20'd10, 0));
		add_row(mk(SIDE_SELL, 8'hFF, 4'd1, 20'hFFFFF, 24'hFFFFFF, 1, 20'hFFFFF, 0));
		// Zero quantity.
		add_row(mk(SIDE_SELL, 8'h12, 4'd0, 20'd0, 24'd0, 1, 20'd0, 0));
		// No cross.
		add_row(mk(SIDE_SELL, 8'h13, 4'd0, 20'd5, 24'd5, 1, 20'd5, 0));
		// Crossing buy and sell, partial fills.
		add_row(mk(SIDE_BUY,  8'h21, 4'd0, 20'd3, 24'd7));
		add_row(mk(SIDE_SELL, 8'h22, 4'd0, 20'd20, 24'd0));
		add_row(mk(SIDE_BUY,  8'h23, 4'd1, 20'd7, 24'hFFFFFF));
		// Equal price ties.
		add_row(mk(SIDE_SELL, 8'h31, 4'd2, 20'd4, 24'd100));
		add_row(mk(SIDE_SELL, 8'h32, 4'd2, 20'd4, 24'd100));
		add_row(mk(SIDE_BUY,  8'h33, 4'd2, 20'd6, 24'd100));
		// Fill one side of ticker 15 then overflow it.
		for (int i = 0; i < ORDERS_PER_SIDE; i++)
			add_row(mk(SIDE_BUY, 8'(i), 4'd15, 20'd1, 24'd50 + 24'(i)));
		add_row(mk(SIDE_BUY, 8'hAA, 4'd15, 20'd9, 24'd1, 1, 20'd9, 1));
		// Sell sweeping the full side.
		add_row(mk(SIDE_SELL, 8'hBB, 4'd15, 20'd20, 24'd50));
	end

	// Output side: random stall pattern with quiet stretches, check every beat.
	always @(posedge clk) begin
		fill_t got, exp_b;
		if (!arst_n) out_stall <= 1'b0;
		else begin
			out_stall <= ($urandom_range(0, 255) < 128) ? ($urandom_range(0, 2) == 0) : 1'b0;
			if (out_valid && !out_stall) begin
				got = '{kind, trade_ticker, seller_id, buyer_id, fill_qty, fill_price, trade_seq,
					rest_qty, book_full, last};
				beats_seen++;
				if (kind == KIND_TRADE) trades_seen++;
				if (kind == KIND_DONE && book_full) full_seen++;
				if (expected_beats.size() == 0) begin
					errors++;
					$display("%0t: mismatch expected no beat actual %p", $time, got);
				end else begin
					exp_b = expected_beats.pop_front();
					if (got !== exp_b) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, exp_b, got);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no handshake.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired, %0d beats still expected", $time,
				expected_beats.size());
			$display("** limit_order_book_matcher_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_order(dir_rows[i].ord);
			if (dir_rows[i].has_done && expected_beats[$] !== dir_rows[i].done_beat) begin
				errors++;
				$display("%0t: directed row %0d expected %p actual %p", $time, i,
					dir_rows[i].done_beat, expected_beats[$]);
			end
		end
		// Hold off until the block has drained everything.
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_beats.size() != 0) @(posedge clk);
		for (int i = 0; i < RANDOM_ORDERS; i++) send_order(random_order());
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (4 * (ORDERS_PER_SIDE + 2)) @(posedge clk);
		$display("Covered %0d orders, %0d beats, %0d trades, %0d dropped remainders.",
			dir_rows.size() + RANDOM_ORDERS, beats_seen, trades_seen, full_seen);
		if (errors == 0 && expected_beats.size() == 0)
			$display("** limit_order_book_matcher_unit: PASSED **");
		else
			$display("** limit_order_book_matcher_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

>>> limit_order_book_matcher_unit.f
rtl/lobm_pkg.sv
rtl/lobm_cell.sv
rtl/lobm_side.sv
rtl/limit_order_book_matcher_unit.sv
dv/limit_order_book_matcher_unit_test.sv
